// ----- rtl/core/tftpv_pkg.sv -----
package tftpv_pkg;

  localparam int MAX_PACKET_BYTES = 1024;
  localparam int NAME_MAX = 255;
  localparam int MODE_MAX = 8;
  localparam int TEXT_MAX = 255;

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int LEN_W = 9;
  localparam int PAY_W = 10;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  // opcodes / awaited types
  localparam logic [2:0] TYPE_RRQ = 3'd1;
  localparam logic [2:0] TYPE_WRQ = 3'd2;
  localparam logic [2:0] TYPE_DATA = 3'd3;
  localparam logic [2:0] TYPE_ACK = 3'd4;
  localparam logic [2:0] TYPE_ERROR = 3'd5;

  // field phases
  localparam logic [2:0] PH_OP = 3'd0;
  localparam logic [2:0] PH_NUM = 3'd1;
  localparam logic [2:0] PH_NAME = 3'd2;
  localparam logic [2:0] PH_MODE = 3'd3;
  localparam logic [2:0] PH_PAY = 3'd4;
  localparam logic [2:0] PH_TEXT = 3'd5;
  localparam logic [2:0] PH_EXCESS = 3'd6;

  // field tags
  localparam logic [2:0] TAG_OPCODE = 3'd0;
  localparam logic [2:0] TAG_NUMBER = 3'd1;
  localparam logic [2:0] TAG_NAME = 3'd2;
  localparam logic [2:0] TAG_MODE = 3'd3;
  localparam logic [2:0] TAG_PAYLOAD = 3'd4;
  localparam logic [2:0] TAG_TEXT = 3'd5;
  localparam logic [2:0] TAG_TERM = 3'd6;
  localparam logic [2:0] TAG_EXCESS = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_WRONG_TYPE = 3'd1;
  localparam logic [2:0] ST_LENGTH = 3'd2;
  localparam logic [2:0] ST_NAME_LONG = 3'd3;
  localparam logic [2:0] ST_MODE_LONG = 3'd4;
  localparam logic [2:0] ST_BAD_MODE = 3'd5;
  localparam logic [2:0] ST_BAD_CODE = 3'd6;

  localparam logic [1:0] MODE_NETASCII = 2'b01;
  localparam logic [1:0] MODE_OCTET = 2'b10;

  localparam logic [15:0] ERR_CODE_MAX = 16'd7;

  // keep the first error; a held length error yields to a later too-long or bad-code error
  function automatic logic [2:0] note_error(input logic [2:0] cur, input logic [2:0] code);
    logic [2:0] res;
    res = cur;
    if (cur == ST_OK ||
        (cur == ST_LENGTH && (code inside {ST_NAME_LONG, ST_MODE_LONG, ST_BAD_CODE}))) begin
      res = code;
    end
    return res;
  endfunction

  function automatic logic [7:0] netascii_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h6E;
      3'd1: c = 8'h65;
      3'd2: c = 8'h74;
      3'd3: c = 8'h61;
      3'd4: c = 8'h73;
      3'd5: c = 8'h63;
      3'd6: c = 8'h69;
      3'd7: c = 8'h69;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] octet_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h6F;
      3'd1: c = 8'h63;
      3'd2: c = 8'h74;
      3'd3: c = 8'h65;
      3'd4: c = 8'h74;
      default: c = 8'h6F;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/tftp_packet_validator_unit.sv -----
// Channel | Handshake           | Payload
// in      | in_valid, in_ready  | data_byte, last, expected_type
// out     | out_valid, out_ready| out_byte, field_tag, done_res, status, number,
//         |                     | payload_length, mode_kind
//
// One request per cycle unless the output stalls: each byte passes one stage of
// compare and counter logic into the result register, out in the next cycle.
// in_ready is high whenever the result register is empty or is being taken.
// Synchronous reset clears the packet state and the result valid flag.
// A stall on the output holds the result and blocks further input.
module tftp_packet_validator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic [2:0]  expected_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [2:0]  field_tag,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [15:0] number,
  output logic [9:0]  payload_length,
  output logic        mode_kind
);

  logic [tftpv_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [2:0]                  latched_type, latched_type_next;
  logic                        opcode_high, opcode_high_next;
  logic [15:0]                 number_reg, number_reg_next;
  logic [2:0]                  field_phase, field_phase_next;
  logic [tftpv_pkg::LEN_W-1:0] string_length, string_length_next;
  logic [1:0]                  mode_match_flags, mode_match_flags_next;
  logic [2:0]                  first_error, first_error_next;

  logic                        accept;
  logic [2:0]                  res_tag;
  logic [2:0]                  res_status;
  logic [15:0]                 res_number;
  logic [9:0]                  res_pay;
  logic                        res_mode;

  always_comb begin
    logic [tftpv_pkg::POS_W-1:0] idx;
    logic [tftpv_pkg::POS_W-1:0] pay_full;
    logic [tftpv_pkg::LEN_W-1:0] len_inc;
    logic [2:0]                  t;
    logic                        ohn;
    logic                        is_req;
    logic [1:0]                  keep;
    logic [2:0]                  fin;

    idx = byte_position;
    t = (idx == '0) ? expected_type : latched_type;
    ohn = (idx == '0) ? (data_byte != 8'd0) : opcode_high;
    is_req = (t == tftpv_pkg::TYPE_RRQ) || (t == tftpv_pkg::TYPE_WRQ);
    len_inc = (string_length < tftpv_pkg::LEN_SAT) ? string_length + 1'b1 : string_length;
    keep = '0;
    pay_full = '0;

    latched_type_next = t;
    opcode_high_next = ohn;
    number_reg_next = number_reg;
    field_phase_next = field_phase;
    string_length_next = string_length;
    mode_match_flags_next = mode_match_flags;
    first_error_next = first_error;
    res_tag = tftpv_pkg::TAG_EXCESS;

    if (idx >= tftpv_pkg::POS_MAX) begin
      first_error_next = tftpv_pkg::note_error(first_error_next, tftpv_pkg::ST_LENGTH);
    end

    case (field_phase)
      tftpv_pkg::PH_OP: begin
        res_tag = tftpv_pkg::TAG_OPCODE;
        if (idx != '0) begin
          if (ohn || data_byte != {5'd0, t} || t < tftpv_pkg::TYPE_RRQ ||
              t > tftpv_pkg::TYPE_ERROR) begin
            first_error_next = tftpv_pkg::note_error(first_error_next,
                                                     tftpv_pkg::ST_WRONG_TYPE);
          end
          if (is_req) begin
            field_phase_next = tftpv_pkg::PH_NAME;
          end else if (t >= tftpv_pkg::TYPE_DATA && t <= tftpv_pkg::TYPE_ERROR) begin
            field_phase_next = tftpv_pkg::PH_NUM;
          end else begin
            field_phase_next = tftpv_pkg::PH_EXCESS;
          end
        end
      end
      tftpv_pkg::PH_NUM: begin
        res_tag = tftpv_pkg::TAG_NUMBER;
        number_reg_next = {number_reg[7:0], data_byte};
        if (idx >= tftpv_pkg::POS_W'(3)) begin
          if (t == tftpv_pkg::TYPE_ERROR && number_reg_next > tftpv_pkg::ERR_CODE_MAX) begin
            first_error_next = tftpv_pkg::note_error(first_error_next,
                                                     tftpv_pkg::ST_BAD_CODE);
          end
          if (t == tftpv_pkg::TYPE_DATA) begin
            field_phase_next = tftpv_pkg::PH_PAY;
          end else if (t == tftpv_pkg::TYPE_ERROR) begin
            field_phase_next = tftpv_pkg::PH_TEXT;
          end else begin
            field_phase_next = tftpv_pkg::PH_EXCESS;
          end
        end
      end
      tftpv_pkg::PH_NAME: begin
        if (data_byte == 8'd0) begin
          res_tag = tftpv_pkg::TAG_TERM;
          string_length_next = '0;
          field_phase_next = tftpv_pkg::PH_MODE;
        end else begin
          res_tag = tftpv_pkg::TAG_NAME;
          string_length_next = len_inc;
          if (len_inc > tftpv_pkg::LEN_W'(tftpv_pkg::NAME_MAX)) begin
            first_error_next = tftpv_pkg::note_error(first_error_next,
                                                     tftpv_pkg::ST_NAME_LONG);
          end
        end
      end
      tftpv_pkg::PH_MODE: begin
        if (data_byte == 8'd0) begin
          res_tag = tftpv_pkg::TAG_TERM;
          keep = {string_length == tftpv_pkg::LEN_W'(5), string_length == tftpv_pkg::LEN_W'(8)};
          mode_match_flags_next = mode_match_flags & keep;
          field_phase_next = tftpv_pkg::PH_EXCESS;
        end else begin
          res_tag = tftpv_pkg::TAG_MODE;
          // drop a candidate mode as soon as a character misses
          if (string_length >= tftpv_pkg::LEN_W'(8) ||
              tftpv_pkg::netascii_char(string_length[2:0]) != data_byte) begin
            mode_match_flags_next = mode_match_flags_next & tftpv_pkg::MODE_OCTET;
          end
          if (string_length >= tftpv_pkg::LEN_W'(5) ||
              tftpv_pkg::octet_char(string_length[2:0]) != data_byte) begin
            mode_match_flags_next = mode_match_flags_next & tftpv_pkg::MODE_NETASCII;
          end
          string_length_next = len_inc;
          if (len_inc > tftpv_pkg::LEN_W'(tftpv_pkg::MODE_MAX)) begin
            first_error_next = tftpv_pkg::note_error(first_error_next,
                                                     tftpv_pkg::ST_MODE_LONG);
          end
        end
      end
      tftpv_pkg::PH_TEXT: begin
        if (data_byte == 8'd0) begin
          res_tag = tftpv_pkg::TAG_TERM;
          field_phase_next = tftpv_pkg::PH_EXCESS;
        end else begin
          res_tag = tftpv_pkg::TAG_TEXT;
          string_length_next = len_inc;
          if (len_inc > tftpv_pkg::LEN_W'(tftpv_pkg::TEXT_MAX)) begin
            first_error_next = tftpv_pkg::note_error(first_error_next,
                                                     tftpv_pkg::ST_NAME_LONG);
          end
        end
      end
      tftpv_pkg::PH_PAY: begin
        res_tag = tftpv_pkg::TAG_PAYLOAD;
      end
      default: begin
        res_tag = tftpv_pkg::TAG_EXCESS;
        if (is_req || t == tftpv_pkg::TYPE_ACK || t == tftpv_pkg::TYPE_ERROR) begin
          first_error_next = tftpv_pkg::note_error(first_error_next, tftpv_pkg::ST_LENGTH);
        end
      end
    endcase

    // end-of-packet checks, used only for the verdict on the last byte
    fin = first_error_next;
    if (idx == '0) begin
      fin = tftpv_pkg::note_error(fin, tftpv_pkg::ST_LENGTH);
    end
    if (is_req) begin
      if (field_phase_next != tftpv_pkg::PH_EXCESS) begin
        fin = tftpv_pkg::note_error(fin, tftpv_pkg::ST_LENGTH);
      end
      if (fin == tftpv_pkg::ST_OK && mode_match_flags_next == 2'b00) begin
        fin = tftpv_pkg::ST_BAD_MODE;
      end
    end else if (t == tftpv_pkg::TYPE_DATA) begin
      if (idx < tftpv_pkg::POS_W'(3)) begin
        fin = tftpv_pkg::note_error(fin, tftpv_pkg::ST_LENGTH);
      end
    end else if (t == tftpv_pkg::TYPE_ACK) begin
      if (idx != tftpv_pkg::POS_W'(3)) begin
        fin = tftpv_pkg::note_error(fin, tftpv_pkg::ST_LENGTH);
      end
    end else if (t == tftpv_pkg::TYPE_ERROR) begin
      if (field_phase_next != tftpv_pkg::PH_EXCESS) begin
        fin = tftpv_pkg::note_error(fin, tftpv_pkg::ST_LENGTH);
      end
    end

    res_status = fin;
    res_number = (t >= tftpv_pkg::TYPE_DATA && t <= tftpv_pkg::TYPE_ERROR) ?
                 number_reg_next : 16'd0;
    pay_full = idx - tftpv_pkg::POS_W'(3);
    res_pay = (t == tftpv_pkg::TYPE_DATA && fin == tftpv_pkg::ST_OK) ?
              pay_full[9:0] : 10'd0;
    res_mode = is_req && fin == tftpv_pkg::ST_OK && mode_match_flags_next[1];

    if (idx < tftpv_pkg::POS_MAX) begin
      byte_position_next = idx + 1'b1;
    end else begin
      byte_position_next = idx;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      latched_type <= '0;
      opcode_high <= 1'b0;
      number_reg <= '0;
      field_phase <= tftpv_pkg::PH_OP;
      string_length <= '0;
      mode_match_flags <= 2'b11;
      first_error <= tftpv_pkg::ST_OK;
    end else if (accept) begin
      if (last) begin
        byte_position <= '0;
        latched_type <= '0;
        opcode_high <= 1'b0;
        number_reg <= '0;
        field_phase <= tftpv_pkg::PH_OP;
        string_length <= '0;
        mode_match_flags <= 2'b11;
        first_error <= tftpv_pkg::ST_OK;
      end else begin
        byte_position <= byte_position_next;
        latched_type <= latched_type_next;
        opcode_high <= opcode_high_next;
        number_reg <= number_reg_next;
        field_phase <= field_phase_next;
        string_length <= string_length_next;
        mode_match_flags <= mode_match_flags_next;
        first_error <= first_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte <= data_byte;
      field_tag <= res_tag;
      done_res <= last;
      status <= last ? res_status : tftpv_pkg::ST_OK;
      number <= last ? res_number : 16'd0;
      payload_length <= last ? res_pay : 10'd0;
      mode_kind <= last && res_mode;
    end
  end

endmodule

// ----- tb/tftp_packet_validator_unit_tb.sv -----
module tftp_packet_validator_unit_tb;
  import tftpv_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_START = 600;
  localparam int HOLD_CYCLES = 200;
  localparam logic [63:0] NETASCII_STR = "netascii";
  localparam logic [39:0] OCTET_STR = "octet";

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [2:0]       tag;
    logic             done;
    logic [2:0]       status;
    logic [15:0]      number;
    logic [PAY_W-1:0] pay_len;
    logic             mode_kind;
  } pkt_result_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        lst;
    logic [2:0]  et;
    logic        drain;
    logic        typed;
    pkt_result_t want;
  } byte_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'h00;
  logic last = 1'b0;
  logic [2:0] expected_type = TYPE_RRQ;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] field_tag;
  logic done_res;
  logic [2:0] status;
  logic [15:0] number;
  logic [9:0] payload_length;
  logic mode_kind;

  tftp_packet_validator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last(last), .expected_type(expected_type),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .field_tag(field_tag), .done_res(done_res), .status(status),
    .number(number), .payload_length(payload_length), .mode_kind(mode_kind)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_req_t   req_q [$];
  pkt_result_t verdict_q [$];
  logic [7:0]  pkt_buf [$];
  int          mismatches = 0;

  // directed requests; the last byte of each packet carries its verdict typed in
  byte_req_t directed_rows [25] = '{
    // a lone byte is too short to be any packet
    {8'hFF, 1'b1, TYPE_RRQ, 2'b01, 8'hFF, TAG_OPCODE, 1'b1, ST_LENGTH, 16'h0000, 10'd0, 1'b0},
    // ACK with the largest block number
    {8'h00, 1'b0, TYPE_ACK, 2'b00, 42'd0},
    {8'h04, 1'b0, 3'd0, 2'b00, 42'd0},
    {8'hFF, 1'b0, 3'd7, 2'b00, 42'd0},
    {8'hFF, 1'b1, 3'd2, 2'b01, 8'hFF, TAG_NUMBER, 1'b1, ST_OK, 16'hFFFF, 10'd0, 1'b0},
    // DATA with no payload
    {8'h00, 1'b0, TYPE_DATA, 2'b00, 42'd0},
    {8'h03, 1'b0, 3'd5, 2'b00, 42'd0},
    {8'h00, 1'b0, 3'd0, 2'b00, 42'd0},
    {8'h01, 1'b1, 3'd1, 2'b01, 8'h01, TAG_NUMBER, 1'b1, ST_OK, 16'h0001, 10'd0, 1'b0},
    // ERROR whose code is one past the allowed range
    {8'h00, 1'b0, TYPE_ERROR, 2'b00, 42'd0},
    {8'h05, 1'b0, 3'd4, 2'b00, 42'd0},
    {8'h00, 1'b0, 3'd3, 2'b00, 42'd0},
    {8'h08, 1'b0, 3'd6, 2'b00, 42'd0},
    {8'h00, 1'b1, 3'd0, 2'b01, 8'h00, TAG_TERM, 1'b1, ST_BAD_CODE, 16'h0008, 10'd0, 1'b0},
    // awaited type outside the opcode range
    {8'h00, 1'b0, 3'd7, 2'b00, 42'd0},
    {8'h07, 1'b1, 3'd7, 2'b01, 8'h07, TAG_OPCODE, 1'b1, ST_WRONG_TYPE, 16'h0000, 10'd0, 1'b0},
    // RRQ with an empty filename in octet mode
    {8'h00, 1'b0, TYPE_RRQ, 2'b00, 42'd0},
    {8'h01, 1'b0, 3'd2, 2'b00, 42'd0},
    {8'h00, 1'b0, 3'd1, 2'b00, 42'd0},
    {8'h6F, 1'b0, 3'd6, 2'b00, 42'd0},
    {8'h63, 1'b0, 3'd5, 2'b00, 42'd0},
    {8'h74, 1'b0, 3'd4, 2'b00, 42'd0},
    {8'h65, 1'b0, 3'd3, 2'b00, 42'd0},
    {8'h74, 1'b0, 3'd2, 2'b00, 42'd0},
    {8'h00, 1'b1, 3'd7, 2'b01, 8'h00, TAG_TERM, 1'b1, ST_OK, 16'h0000, 10'd0, 1'b1}
  };

  // packet tracking state
  logic [POS_W-1:0] pos;
  logic [2:0]       held_type;
  logic [7:0]       op_hi;
  logic [15:0]      num_acc;
  logic [2:0]       phase;
  logic [LEN_W-1:0] str_len;
  logic [1:0]       mode_ok;
  logic [2:0]       fault;

  function automatic void clear_packet_state();
    pos = '0;
    held_type = '0;
    op_hi = '0;
    num_acc = '0;
    phase = PH_OP;
    str_len = '0;
    mode_ok = MODE_NETASCII | MODE_OCTET;
    fault = ST_OK;
  endfunction

  // first fault sticks, but a length fault gives way to a too-long or bad-code fault
  function automatic void record_fault(input logic [2:0] code);
    if (fault == ST_OK ||
        (fault == ST_LENGTH &&
         (code == ST_NAME_LONG || code == ST_MODE_LONG || code == ST_BAD_CODE)))
      fault = code;
  endfunction

  function automatic void bump_str_len();
    if (str_len != LEN_SAT) str_len = str_len + 1'b1;
  endfunction

  function automatic pkt_result_t classify_byte(input logic [7:0] b, input logic lst,
                                                input logic [2:0] et);
    logic [POS_W-1:0] idx;
    logic [2:0] t;
    logic req;
    logic [1:0] keep;
    pkt_result_t r;
    idx = pos;
    r = '0;
    if (idx == 0) begin
      held_type = et;
      op_hi = b;
    end
    t = held_type;
    req = (t == TYPE_RRQ || t == TYPE_WRQ);
    if (idx >= MAX_PACKET_BYTES) record_fault(ST_LENGTH);
    case (phase)
      PH_OP: begin
        r.tag = TAG_OPCODE;
        if (idx >= 1) begin
          if (op_hi != 8'h00 || b != {5'd0, t} || t < TYPE_RRQ || t > TYPE_ERROR)
            record_fault(ST_WRONG_TYPE);
          if (req) phase = PH_NAME;
          else if (t >= TYPE_DATA && t <= TYPE_ERROR) phase = PH_NUM;
          else phase = PH_EXCESS;
        end
      end
      PH_NUM: begin
        r.tag = TAG_NUMBER;
        num_acc = {num_acc[7:0], b};
        if (idx >= 3) begin
          if (t == TYPE_ERROR && num_acc > ERR_CODE_MAX) record_fault(ST_BAD_CODE);
          if (t == TYPE_DATA) phase = PH_PAY;
          else if (t == TYPE_ERROR) phase = PH_TEXT;
          else phase = PH_EXCESS;
        end
      end
      PH_NAME: begin
        if (b == 8'h00) begin
          r.tag = TAG_TERM;
          str_len = '0;
          phase = PH_MODE;
        end else begin
          r.tag = TAG_NAME;
          bump_str_len();
          if (str_len > NAME_MAX) record_fault(ST_NAME_LONG);
        end
      end
      PH_MODE: begin
        if (b == 8'h00) begin
          r.tag = TAG_TERM;
          keep = (str_len == 8 ? MODE_NETASCII : 2'b00) | (str_len == 5 ? MODE_OCTET : 2'b00);
          mode_ok = mode_ok & keep;
          phase = PH_EXCESS;
        end else begin
          r.tag = TAG_MODE;
          if (str_len >= 8) mode_ok = mode_ok & MODE_OCTET;
          else if (NETASCII_STR[63 - 8*str_len[2:0] -: 8] != b) mode_ok = mode_ok & MODE_OCTET;
          if (str_len >= 5) mode_ok = mode_ok & MODE_NETASCII;
          else if (OCTET_STR[39 - 8*str_len[2:0] -: 8] != b) mode_ok = mode_ok & MODE_NETASCII;
          bump_str_len();
          if (str_len > MODE_MAX) record_fault(ST_MODE_LONG);
        end
      end
      PH_TEXT: begin
        if (b == 8'h00) begin
          r.tag = TAG_TERM;
          phase = PH_EXCESS;
        end else begin
          r.tag = TAG_TEXT;
          bump_str_len();
          if (str_len > TEXT_MAX) record_fault(ST_NAME_LONG);
        end
      end
      PH_PAY: r.tag = TAG_PAYLOAD;
      default: begin
        r.tag = TAG_EXCESS;
        if (req || t == TYPE_ACK || t == TYPE_ERROR) record_fault(ST_LENGTH);
      end
    endcase
    r.out_byte = b;
    r.done = lst;
    if (!lst) begin
      if (pos < POS_MAX) pos = pos + 1'b1;
      return r;
    end
    // verdict on the last byte
    if (idx < 1) record_fault(ST_LENGTH);
    if (req) begin
      if (phase != PH_EXCESS) record_fault(ST_LENGTH);
      if (fault == ST_OK && mode_ok == 2'b00) record_fault(ST_BAD_MODE);
    end else if (t == TYPE_DATA) begin
      if (idx < 3) record_fault(ST_LENGTH);
    end else if (t == TYPE_ACK) begin
      if (idx != 3) record_fault(ST_LENGTH);
    end else if (t == TYPE_ERROR) begin
      if (phase != PH_EXCESS) record_fault(ST_LENGTH);
    end
    r.status = fault;
    if (t >= TYPE_DATA && t <= TYPE_ERROR) r.number = num_acc;
    if (t == TYPE_DATA && fault == ST_OK) r.pay_len = PAY_W'(idx + 1 - 4);
    if (req && fault == ST_OK) r.mode_kind = |(mode_ok & MODE_OCTET);
    clear_packet_state();
    return r;
  endfunction

  function automatic void compare_field(input string fname, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h got %0h", $time, fname, want_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic add_chars(input int count, input int lowest);
    for (int i = 0; i < count; i++) pkt_buf.push_back(8'($urandom_range(lowest, 255)));
  endtask

  // request side: bursts and gaps; also tracks and checks results in one place
  int burst_left = 0;
  int gap_left = 0;
  int quiet = 0;

  always @(posedge clk) begin : traffic
    pkt_result_t want;
    if (rst) begin
      in_valid <= 1'b0;
      clear_packet_state();
      quiet = 0;
    end else begin
      if (in_valid && in_ready) begin
        want = classify_byte(data_byte, last, expected_type);
        if (req_q[0].typed) want = req_q[0].want;
        verdict_q.push_back(want);
        req_q.delete(0);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() == 0 || (req_q[0].drain && verdict_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          data_byte <= req_q[0].b;
          last <= req_q[0].lst;
          expected_type <= req_q[0].et;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with nothing expected, byte %h", $time, out_byte);
          mismatches++;
        end else begin
          want = verdict_q[0];
          verdict_q.delete(0);
          compare_field("out_byte", 16'(want.out_byte), 16'(out_byte));
          compare_field("field_tag", 16'(want.tag), 16'(field_tag));
          compare_field("done_res", 16'(want.done), 16'(done_res));
          compare_field("status", 16'(want.status), 16'(status));
          compare_field("number", want.number, number);
          compare_field("payload_length", 16'(want.pay_len), 16'(payload_length));
          compare_field("mode_kind", 16'(want.mode_kind), 16'(mode_kind));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side: its own stall pattern plus one long hold-off
  int rcv_cycle = 0;
  int pat_mode = 0;
  int pat_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rcv_cycle++;
      if (rcv_cycle >= HOLD_START && rcv_cycle < HOLD_START + HOLD_CYCLES) begin
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 2);
          pat_left = $urandom_range(10, 60);
        end else begin
          pat_left--;
        end
        case (pat_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (rcv_cycle % 4 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    byte_req_t it;
    logic [2:0] et;
    int small_items;
    int pkt_n;
    int kind;
    int n;
    int flip;
    int cut;
    for (int i = 0; i < 25; i++) req_q.push_back(directed_rows[i]);
    small_items = 0;
    pkt_n = 0;
    while (small_items < RANDOM_ITEMS) begin
      pkt_buf.delete();
      kind = $urandom_range(0, 9);
      if (pkt_n == 4) begin
        // full-size DATA: largest payload length
        et = TYPE_DATA;
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back({5'd0, TYPE_DATA});
        add_chars(2 + MAX_PACKET_BYTES - 4, 0);
      end else if (pkt_n == 9) begin
        // filename past the packet limit: length saturation, too long, overlong
        et = TYPE_WRQ;
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back({5'd0, TYPE_WRQ});
        add_chars(MAX_PACKET_BYTES + 6, 1);
        pkt_buf.push_back(8'h00);
        for (int i = 0; i < 5; i++) pkt_buf.push_back(OCTET_STR[39 - 8*i -: 8]);
        pkt_buf.push_back(8'h00);
      end else if (pkt_n == 14) begin
        et = TYPE_ERROR;
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back({5'd0, TYPE_ERROR});
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back(8'h03);
        add_chars(TEXT_MAX + 5, 1);
        pkt_buf.push_back(8'h00);
      end else begin
        case (kind)
          0, 1, 2: begin
            et = ($urandom_range(0, 1) != 0) ? TYPE_WRQ : TYPE_RRQ;
            pkt_buf.push_back(8'h00);
            pkt_buf.push_back({5'd0, et});
            add_chars($urandom_range(0, 10), 1);
            pkt_buf.push_back(8'h00);
            n = $urandom_range(0, 5);
            // now and then flip the case of one mode letter
            flip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : 8;
            if (n <= 2) begin
              for (int i = 0; i < 8; i++)
                pkt_buf.push_back(NETASCII_STR[63 - 8*i -: 8] ^ (i == flip ? 8'h20 : 8'h00));
            end else if (n <= 4) begin
              for (int i = 0; i < 5; i++)
                pkt_buf.push_back(OCTET_STR[39 - 8*i -: 8] ^ (i == flip ? 8'h20 : 8'h00));
            end else begin
              add_chars($urandom_range(0, 11), 1);
            end
            pkt_buf.push_back(8'h00);
            if ($urandom_range(0, 7) == 0) add_chars($urandom_range(1, 3), 0);
          end
          3, 4: begin
            et = TYPE_DATA;
            pkt_buf.push_back(8'h00);
            pkt_buf.push_back({5'd0, TYPE_DATA});
            add_chars(2 + $urandom_range(0, 24), 0);
          end
          5: begin
            et = TYPE_ACK;
            pkt_buf.push_back(8'h00);
            pkt_buf.push_back({5'd0, TYPE_ACK});
            add_chars(2, 0);
            if ($urandom_range(0, 5) == 0) add_chars($urandom_range(1, 3), 0);
          end
          6, 7: begin
            et = TYPE_ERROR;
            pkt_buf.push_back(8'h00);
            pkt_buf.push_back({5'd0, TYPE_ERROR});
            pkt_buf.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00);
            pkt_buf.push_back(8'($urandom_range(0, 9)));
            add_chars($urandom_range(0, 12), 1);
            pkt_buf.push_back(8'h00);
            if ($urandom_range(0, 7) == 0) add_chars($urandom_range(1, 3), 0);
          end
          default: begin
            et = 3'($urandom_range(0, 7));
            add_chars($urandom_range(1, 6), 0);
          end
        endcase
        // break some packets: cut short, await the wrong type, or damage the opcode
        if (kind < 8) begin
          case ($urandom_range(0, 11))
            0: begin
              cut = $urandom_range(1, pkt_buf.size());
              while (pkt_buf.size() > cut) pkt_buf.delete(pkt_buf.size() - 1);
            end
            1: et = 3'($urandom_range(0, 7));
            2: pkt_buf[$urandom_range(0, 1)] = 8'($urandom);
            default: ;
          endcase
        end
      end
      for (int i = 0; i < pkt_buf.size(); i++) begin
        it = '0;
        it.b = pkt_buf[i];
        it.lst = (i == pkt_buf.size() - 1);
        it.et = (i == 0) ? et : 3'($urandom_range(0, 7));
        // hold the packet back until every result so far has drained
        it.drain = (i == 0) && (pkt_n % 30 == 20);
        req_q.push_back(it);
      end
      small_items += pkt_buf.size();
      pkt_n++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
